>>> rtl/rotary_encoder_detent_decoder_assert.svh
// Assertion macros for the rotary encoder detent decoder.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ROTARY_ENCODER_DETENT_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_DETENT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RED_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rotary encoder decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define RED_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rotary encoder decoder: next-cycle check failed");

`endif

>>> rtl/red_pkg.sv
// Shared types, constants and helpers for the rotary encoder detent decoder.
// No dependencies; used by red_mult and rotary_encoder_detent_decoder.
`timescale 1ns / 1ps
`default_nettype none

package red_pkg;

  // Fixed field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THRESH_W = 10;
  localparam int unsigned LOCK_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned MOVE_W   = 7;

  // Default detent size
  localparam int unsigned PULSES_PER_DETENT = 4;

  // One second in ticks
  localparam logic [THRESH_W-1:0] MS_PER_S = 10'd1000;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESH_100X_RST = 10'd160;
  localparam logic [THRESH_W-1:0] THRESH_10X_RST  = 10'd80;
  localparam logic [THRESH_W-1:0] THRESH_5X_RST   = 10'd0;
  localparam logic [LOCK_W-1:0]   LOCKOUT_RST     = 16'd20;
  localparam logic [LOCK_W-1:0]   CLICK_LOCK_RST  = 16'd300;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CW   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CCW  = 2'd2;

  // Multiplier values
  localparam logic [MOVE_W-1:0] MULT_0   = 7'd0;
  localparam logic [MOVE_W-1:0] MULT_1   = 7'd1;
  localparam logic [MOVE_W-1:0] MULT_5   = 7'd5;
  localparam logic [MOVE_W-1:0] MULT_10  = 7'd10;
  localparam logic [MOVE_W-1:0] MULT_100 = 7'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_ENABLE  = 3'd0,
    REG_REVERSE      = 3'd1,
    REG_THRESH_100X  = 3'd2,
    REG_THRESH_10X   = 3'd3,
    REG_THRESH_5X    = 3'd4,
    REG_LOCKOUT      = 3'd5,
    REG_CLICK_LOCK   = 3'd6
  } cfg_reg_t;

  // Rate thresholds handed to the multiplier select
  typedef struct packed {
    logic [THRESH_W-1:0] t100;
    logic [THRESH_W-1:0] t10;
    logic [THRESH_W-1:0] t5;
  } thresh_t;

  // Pin code {B,A} to quadrature phase: 00, 10, 11, 01 are phases 0..3
  function automatic logic [1:0] phase_of(input logic [1:0] code);
    logic [1:0] ph;
    unique case (code)
      2'b00:   ph = 2'd0;
      2'b10:   ph = 2'd1;
      2'b11:   ph = 2'd2;
      default: ph = 2'd3;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

>>> rtl/red_mult.sv
// Move multiplier select from the interval since the previous detent.
// Depends on red_pkg for widths, threshold struct and multiplier values.
`timescale 1ns / 1ps
`default_nettype none

module red_mult (
  input  wire logic [red_pkg::TIME_W-1:0] dt,
  input  wire red_pkg::thresh_t           thresh,
  output logic [red_pkg::MOVE_W-1:0]      mult
);

  // 1000/dt >= thr tested as thr*dt <= 1000; a dt above 1000 fails unless thr is 0
  function automatic logic rate_at_least(input logic [red_pkg::TIME_W-1:0] d,
                                         input logic [red_pkg::THRESH_W-1:0] thr);
    logic                            short_dt;
    logic [2*red_pkg::THRESH_W-1:0]  prod;
    short_dt = (d <= red_pkg::TIME_W'(red_pkg::MS_PER_S));
    prod     = thr * d[red_pkg::THRESH_W-1:0];
    return (d == '0) || (thr == '0) ||
           (short_dt && (prod <= (2*red_pkg::THRESH_W)'(red_pkg::MS_PER_S)));
  endfunction

  logic hit100, hit10, hit5;

  assign hit100 = rate_at_least(dt, thresh.t100);
  assign hit10  = rate_at_least(dt, thresh.t10);
  assign hit5   = (thresh.t5 != '0) && rate_at_least(dt, thresh.t5);

  // Tiers in priority order
  always_comb begin
    if (hit100) begin
      mult = red_pkg::MULT_100;
    end else if (hit10) begin
      mult = red_pkg::MULT_10;
    end else if (hit5) begin
      mult = red_pkg::MULT_5;
    end else begin
      mult = red_pkg::MULT_1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rotary_encoder_detent_decoder.sv
// Rotary encoder detent decoder: one item per 1 ms tick, one result per item.
// Depends on red_pkg, red_mult and rotary_encoder_detent_decoder_assert.svh.
// Input register, then result register; 1 item per cycle sustained while the
// result channel is not stalled, with the state updated between the two registers.
// Synchronous active-high reset clears the time counters, phase, pulse count,
// valid flags and restores the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "rotary_encoder_detent_decoder_assert.svh"

module rotary_encoder_detent_decoder #(
  parameter int unsigned PULSES_PER_DETENT = red_pkg::PULSES_PER_DETENT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [red_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [red_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          pin_a,
  input  wire logic                          pin_b,
  input  wire logic                          button,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [red_pkg::EVENT_W-1:0]        event_res,
  output logic [red_pkg::MOVE_W-1:0]         move_value
);

  localparam int unsigned CountW = $clog2(PULSES_PER_DETENT + 1) + 1;
  localparam logic signed [CountW-1:0] PosLim = CountW'(PULSES_PER_DETENT);
  localparam logic signed [CountW-1:0] NegLim = -PosLim;
  localparam logic signed [CountW-1:0] One    = CountW'(1);

  localparam int unsigned TW = red_pkg::TIME_W;

  // Configuration registers
  logic                          rate_enable;
  logic                          reverse_direction;
  red_pkg::thresh_t              thresh;
  logic [red_pkg::LOCK_W-1:0]    lockout_ms;
  logic [red_pkg::LOCK_W-1:0]    click_lockout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_enable       <= 1'b0;
      reverse_direction <= 1'b0;
      thresh.t100       <= red_pkg::THRESH_100X_RST;
      thresh.t10        <= red_pkg::THRESH_10X_RST;
      thresh.t5         <= red_pkg::THRESH_5X_RST;
      lockout_ms        <= red_pkg::LOCKOUT_RST;
      click_lockout_ms  <= red_pkg::CLICK_LOCK_RST;
    end else if (cfg_we) begin
      unique case (red_pkg::cfg_reg_t'(cfg_index))
        red_pkg::REG_RATE_ENABLE: rate_enable       <= cfg_data[0];
        red_pkg::REG_REVERSE:     reverse_direction <= cfg_data[0];
        red_pkg::REG_THRESH_100X: thresh.t100       <= cfg_data[red_pkg::THRESH_W-1:0];
        red_pkg::REG_THRESH_10X:  thresh.t10        <= cfg_data[red_pkg::THRESH_W-1:0];
        red_pkg::REG_THRESH_5X:   thresh.t5         <= cfg_data[red_pkg::THRESH_W-1:0];
        red_pkg::REG_LOCKOUT:     lockout_ms        <= cfg_data[red_pkg::LOCK_W-1:0];
        red_pkg::REG_CLICK_LOCK:  click_lockout_ms  <= cfg_data[red_pkg::LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic       s1_valid;
  logic [1:0] s1_code;
  logic       s1_btn;
  logic       s1_move;
  logic       in_take;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_code <= {pin_b, pin_a};
      s1_btn  <= button;
    end
  end

  // Decoder state
  logic [TW-1:0]            now_ms, lockout_until, click_until, last_detent_time;
  logic [1:0]               last_phase;
  logic signed [CountW-1:0] pulse_count;

  logic [TW-1:0]            now;
  logic [TW-1:0]            lock_diff, click_diff;
  logic                     locked, click_wait, go;
  logic [1:0]               np, op;
  logic signed [CountW-1:0] cnt_new;
  logic                     detent, cw;
  logic [TW-1:0]            dt;
  logic [red_pkg::MOVE_W-1:0] rate_mult, mult;

  // Time window checks
  assign now        = now_ms + TW'(1);
  assign lock_diff  = now - lockout_until;
  assign click_diff = now - click_until;
  assign locked     = lock_diff[TW-1];
  assign click_wait = s1_btn && click_diff[TW-1];
  assign go         = !locked && !click_wait;

  // Quadrature step
  assign np = red_pkg::phase_of(s1_code);
  assign op = red_pkg::phase_of(last_phase);

  always_comb begin
    if (np == op + 2'd1) begin
      cnt_new = pulse_count + One;
    end else if (np == op - 2'd1) begin
      cnt_new = pulse_count - One;
    end else begin
      cnt_new = pulse_count;
    end
  end

  assign detent = go && ((cnt_new >= PosLim) || (cnt_new <= NegLim));
  assign cw     = (cnt_new > 0) != reverse_direction;
  assign dt     = now - last_detent_time;

  red_mult u_mult (
    .dt     (dt),
    .thresh (thresh),
    .mult   (rate_mult)
  );

  assign mult = (rate_enable && (last_detent_time != '0)) ? rate_mult : red_pkg::MULT_1;

  // State update as the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms           <= '0;
      lockout_until    <= '0;
      click_until      <= '0;
      last_detent_time <= '0;
      last_phase       <= '0;
      pulse_count      <= '0;
    end else if (s1_move) begin
      now_ms <= now;
      if (go) begin
        last_phase <= s1_code;
        if (s1_btn) begin
          click_until <= now + TW'(click_lockout_ms);
        end
        if (detent) begin
          pulse_count   <= '0;
          lockout_until <= now + TW'(lockout_ms);
          if (rate_enable) begin
            last_detent_time <= now;
          end
        end else begin
          pulse_count <= cnt_new;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      if (detent) begin
        event_res  <= cw ? red_pkg::EV_CW : red_pkg::EV_CCW;
        move_value <= mult;
      end else begin
        event_res  <= red_pkg::EV_NONE;
        move_value <= red_pkg::MULT_0;
      end
    end
  end

  // Checks
  `RED_ASSERT_NOW(a_none_zero, out_valid && (event_res == red_pkg::EV_NONE), move_value == red_pkg::MULT_0)
  `RED_ASSERT_NOW(a_mult_legal, out_valid && (event_res != red_pkg::EV_NONE), (move_value == red_pkg::MULT_1) || (move_value == red_pkg::MULT_5) || (move_value == red_pkg::MULT_10) || (move_value == red_pkg::MULT_100))
  `RED_ASSERT_NOW(a_no_rate_unit, out_valid && (event_res != red_pkg::EV_NONE) && !rate_enable, move_value == red_pkg::MULT_1)
  `RED_ASSERT_NEXT(a_s1_hold, s1_valid && in_stall, s1_valid && $stable(s1_code) && $stable(s1_btn))

endmodule

`default_nettype wire

>>> dv/tb_rotary_encoder_detent_decoder.sv
// Self-checking testbench for rotary_encoder_detent_decoder: tick items with
// knob rotations in and detent reports out, checked against an in-bench predictor.
// Depends on red_pkg and the rotary_encoder_detent_decoder RTL.
`timescale 1ns / 1ps

module tb_rotary_encoder_detent_decoder;

  localparam int RUN_LIMIT_NS = 3_000_000;
  localparam int DETENT = int'(red_pkg::PULSES_PER_DETENT);

  // Pin codes {B,A} for the four quadrature phases
  localparam logic [1:0] PH0_CODE = 2'b00;
  localparam logic [1:0] PH1_CODE = 2'b10;
  localparam logic [1:0] PH2_CODE = 2'b11;
  localparam logic [1:0] PH3_CODE = 2'b01;
  localparam logic [1:0] POS_CODE [4] = '{PH0_CODE, PH1_CODE, PH2_CODE, PH3_CODE};
  // Inverse map, indexed by pin code
  localparam logic [1:0] CODE_POS [4] = '{2'd0, 2'd3, 2'd1, 2'd2};

  typedef struct packed {
    logic [red_pkg::EVENT_W-1:0] ev;
    logic [red_pkg::MOVE_W-1:0]  mv;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [red_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [red_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic pin_a = 1'b0;
  logic pin_b = 1'b0;
  logic button = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [red_pkg::EVENT_W-1:0] event_res;
  logic [red_pkg::MOVE_W-1:0] move_value;

  rotary_encoder_detent_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .button     (button),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .move_value (move_value)
  );

  always #5 clk = ~clk;

  // Predictor copy of the configuration registers
  logic                         reg_rate    = 1'b0;
  logic                         reg_reverse = 1'b0;
  logic [red_pkg::THRESH_W-1:0] reg_t100    = red_pkg::THRESH_100X_RST;
  logic [red_pkg::THRESH_W-1:0] reg_t10     = red_pkg::THRESH_10X_RST;
  logic [red_pkg::THRESH_W-1:0] reg_t5      = red_pkg::THRESH_5X_RST;
  logic [red_pkg::LOCK_W-1:0]   reg_lockout = red_pkg::LOCKOUT_RST;
  logic [red_pkg::LOCK_W-1:0]   reg_click   = red_pkg::CLICK_LOCK_RST;

  // Predictor copy of the decoder state
  logic [red_pkg::TIME_W-1:0] ms_now      = '0;
  logic [red_pkg::TIME_W-1:0] quiet_until = '0;
  logic [red_pkg::TIME_W-1:0] click_until = '0;
  logic [red_pkg::TIME_W-1:0] last_detent = '0;
  logic [1:0]                 prev_code   = PH0_CODE;
  logic signed [3:0]          pulses      = '0;

  tick_result_t pending_reports[$];
  int mismatches = 0;
  int tick_gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // Knob position seen by the stimulus generator
  logic [1:0] knob_pos = 2'd0;
  logic [1:0] knob_dir = 2'd1;

  // Wrapping time compare: t lies before u
  function automatic logic earlier(input logic [red_pkg::TIME_W-1:0] t,
                                   input logic [red_pkg::TIME_W-1:0] u);
    logic [red_pkg::TIME_W-1:0] d;
    d = t - u;
    return d[red_pkg::TIME_W-1];
  endfunction

  // 1000/gap >= thr, evaluated as thr*gap <= 1000; zero gap is infinitely fast
  function automatic logic fast_enough(input logic [red_pkg::TIME_W-1:0] gap,
                                       input logic [red_pkg::THRESH_W-1:0] thr);
    if (gap == '0) return 1'b1;
    return (64'(thr) * 64'(gap)) <= 64'(red_pkg::MS_PER_S);
  endfunction

  // One tick through the decoder; updates predictor state, returns the report
  function automatic tick_result_t decode_tick(input logic a, input logic b, input logic btn);
    tick_result_t r;
    logic [1:0] code;
    logic [1:0] new_ph;
    logic [1:0] old_ph;
    logic [red_pkg::TIME_W-1:0] t;
    logic cw;
    logic [red_pkg::MOVE_W-1:0] mult;
    r.ev = red_pkg::EV_NONE;
    r.mv = red_pkg::MULT_0;
    code = {b, a};
    ms_now = ms_now + 1'b1;
    t = ms_now;
    if (earlier(t, quiet_until)) return r;
    if (btn) begin
      if (earlier(t, click_until)) return r;
      click_until = t + red_pkg::TIME_W'(reg_click);
    end
    if (code != prev_code) begin
      new_ph = CODE_POS[code];
      old_ph = CODE_POS[prev_code];
      if (new_ph == old_ph + 2'd1) pulses = pulses + 4'sd1;
      else if (new_ph == old_ph - 2'd1) pulses = pulses - 4'sd1;
      prev_code = code;
    end
    if (int'(pulses) >= DETENT || int'(pulses) <= -DETENT) begin
      cw = (pulses > 0) != reg_reverse;
      mult = red_pkg::MULT_1;
      if (reg_rate) begin
        if (last_detent != '0) begin
          if (fast_enough(t - last_detent, reg_t100)) mult = red_pkg::MULT_100;
          else if (fast_enough(t - last_detent, reg_t10)) mult = red_pkg::MULT_10;
          else if (reg_t5 != '0 && fast_enough(t - last_detent, reg_t5))
            mult = red_pkg::MULT_5;
        end
        last_detent = t;
      end
      r.ev = cw ? red_pkg::EV_CW : red_pkg::EV_CCW;
      r.mv = mult;
      pulses = '0;
      quiet_until = t + red_pkg::TIME_W'(reg_lockout);
    end
    return r;
  endfunction

  // Receiver: random stalls, or a long hold-off while hold_left runs down
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted report with the oldest predicted one
  always @(posedge clk) begin : check_reports
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report with no item pending: event_res %0d move_value %0d",
               event_res, move_value);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (event_res !== want.ev) begin
          $error("event_res expected %0d actual %0d", want.ev, event_res);
          mismatches++;
        end
        if (move_value !== want.mv) begin
          $error("move_value expected %0d actual %0d", want.mv, move_value);
          mismatches++;
        end
      end
    end
  end

  // Offer one tick item and hold it until accepted
  task automatic send_tick(input logic [1:0] code, input logic btn);
    while ($urandom_range(99) < tick_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_a    <= code[0];
    pin_b    <= code[1];
    button   <= btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(decode_tick(code[0], code[1], btn));
  endtask

  // Stop offering items and wait for every report to come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input red_pkg::cfg_reg_t idx,
                           input logic [red_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      red_pkg::REG_RATE_ENABLE: reg_rate    = val[0];
      red_pkg::REG_REVERSE:     reg_reverse = val[0];
      red_pkg::REG_THRESH_100X: reg_t100    = val[red_pkg::THRESH_W-1:0];
      red_pkg::REG_THRESH_10X:  reg_t10     = val[red_pkg::THRESH_W-1:0];
      red_pkg::REG_THRESH_5X:   reg_t5      = val[red_pkg::THRESH_W-1:0];
      red_pkg::REG_LOCKOUT:     reg_lockout = val[red_pkg::LOCK_W-1:0];
      red_pkg::REG_CLICK_LOCK:  reg_click   = val[red_pkg::LOCK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic rate, input logic rev,
                                input logic [red_pkg::THRESH_W-1:0] t100,
                                input logic [red_pkg::THRESH_W-1:0] t10,
                                input logic [red_pkg::THRESH_W-1:0] t5,
                                input logic [red_pkg::LOCK_W-1:0] lock,
                                input logic [red_pkg::LOCK_W-1:0] click);
    write_reg(red_pkg::REG_RATE_ENABLE, red_pkg::CFG_W'(rate));
    write_reg(red_pkg::REG_REVERSE, red_pkg::CFG_W'(rev));
    write_reg(red_pkg::REG_THRESH_100X, red_pkg::CFG_W'(t100));
    write_reg(red_pkg::REG_THRESH_10X, red_pkg::CFG_W'(t10));
    write_reg(red_pkg::REG_THRESH_5X, red_pkg::CFG_W'(t5));
    write_reg(red_pkg::REG_LOCKOUT, red_pkg::CFG_W'(lock));
    write_reg(red_pkg::REG_CLICK_LOCK, red_pkg::CFG_W'(click));
  endtask

  task automatic set_idling(input int gap, input int stall);
    tick_gap_pct = gap;
    stall_pct    = stall;
  endtask

  // Mostly clean rotation at a varying pace, with reversals, skipped
  // phases, pin noise and bursts of button presses
  task automatic spin_knob(input int items, input int press_pct);
    int pace;
    int roll;
    int press_left;
    logic [1:0] code;
    press_left = 0;
    pace = 75;
    for (int i = 0; i < items; i++) begin
      if (i % 16 == 0) pace = $urandom_range(35, 95);
      roll = $urandom_range(99);
      if (roll < pace) begin
        knob_pos = knob_pos + knob_dir;
      end else if (roll < pace + 4) begin
        knob_dir = -knob_dir;
        knob_pos = knob_pos + knob_dir;
      end else if (roll < pace + 7) begin
        knob_pos = knob_pos + 2'd2;
      end
      code = POS_CODE[knob_pos];
      if ($urandom_range(99) < 4) code = 2'($urandom_range(3));
      if (press_left == 0 && $urandom_range(99) < press_pct)
        press_left = $urandom_range(1, 12);
      send_tick(code, press_left != 0);
      if (press_left != 0) press_left--;
    end
  endtask

  // Register values straight out of reset
  task automatic test_reset_defaults();
    set_idling(0, 0);
    spin_knob(150, 3);
    drain_reports();
  endtask

  // Hand-built sequences: both directions, lockout, skipped phase, held button
  task automatic test_directed_detents();
    apply_settings(1'b1, 1'b0, 10'd250, 10'd100, 10'd50, 16'd3, 16'd5);
    // clockwise detent, then two ticks swallowed by the lockout
    send_tick(PH1_CODE, 1'b0);
    send_tick(PH2_CODE, 1'b0);
    send_tick(PH3_CODE, 1'b0);
    send_tick(PH0_CODE, 1'b0);
    send_tick(PH2_CODE, 1'b0);
    send_tick(PH2_CODE, 1'b0);
    // counterclockwise detent with a measured interval
    send_tick(PH3_CODE, 1'b0);
    send_tick(PH2_CODE, 1'b0);
    send_tick(PH1_CODE, 1'b0);
    send_tick(PH0_CODE, 1'b0);
    // two-phase jump counts nothing
    send_tick(PH0_CODE, 1'b0);
    send_tick(PH0_CODE, 1'b0);
    send_tick(PH2_CODE, 1'b0);
    send_tick(PH0_CODE, 1'b0);
    // held button: one decode, then the click lockout
    send_tick(PH1_CODE, 1'b1);
    send_tick(PH2_CODE, 1'b1);
    send_tick(PH2_CODE, 1'b1);
    send_tick(PH2_CODE, 1'b0);
    send_tick(PH3_CODE, 1'b0);
    send_tick(PH0_CODE, 1'b0);
    send_tick(PH0_CODE, 1'b1);
    knob_pos = 2'd0;
    drain_reports();
  endtask

  // Thresholds chosen so that every multiplier tier is reachable
  task automatic test_rate_tiers();
    apply_settings(1'b1, 1'b0, 10'd250, 10'd100, 10'd50, 16'd0, 16'd0);
    set_idling(0, 0);
    spin_knob(400, 3);
    drain_reports();
  endtask

  // Zero 100x and 10x thresholds always apply, a zero 5x one never does; ones above 1000 never do
  task automatic test_threshold_extremes();
    set_idling(65, 0);
    apply_settings(1'b1, 1'b0, 10'd0, 10'd80, 10'd0, 16'd2, 16'd0);
    spin_knob(120, 3);
    drain_reports();
    apply_settings(1'b1, 1'b0, 10'd1023, 10'd0, 10'd1000, 16'd2, 16'd0);
    spin_knob(120, 3);
    drain_reports();
    apply_settings(1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 16'd0, 16'd0);
    spin_knob(120, 3);
    drain_reports();
  endtask

  // Longest lockouts, then reversed direction without rate mode
  task automatic test_lockouts_and_reverse();
    set_idling(0, 65);
    apply_settings(1'b0, 1'b0, 10'd160, 10'd80, 10'd0, 16'hFFFF, 16'hFFFF);
    spin_knob(60, 30);
    drain_reports();
    apply_settings(1'b0, 1'b1, 10'd160, 10'd80, 10'd0, 16'd20, 16'd300);
    spin_knob(400, 5);
    drain_reports();
  endtask

  task automatic test_random_settings();
    set_idling(36, 36);
    repeat (4) begin
      apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                     10'($urandom_range(1023)), 10'($urandom_range(1023)),
                     10'($urandom_range(1023)), 16'($urandom_range(40)),
                     16'($urandom_range(400)));
      spin_knob(150, 4);
      drain_reports();
    end
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    apply_settings(1'b1, 1'b0, 10'd250, 10'd100, 10'd50, 16'd0, 16'd0);
    set_idling(0, 0);
    hold_left = 400;
    spin_knob(80, 3);
    drain_reports();
    set_idling(36, 36);
    spin_knob(200, 5);
    drain_reports();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_detents();
    test_rate_tiers();
    test_threshold_extremes();
    test_lockouts_and_reverse();
    test_random_settings();
    test_backpressure();
    drain_reports();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
